### rtl/backend_selector_rr_least_conn_defines.svh
// Assertion macros used by the backend selector top level.
`ifndef BACKEND_SELECTOR_RR_LEAST_CONN_DEFINES_SVH
`define BACKEND_SELECTOR_RR_LEAST_CONN_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BSRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bsrl assertion failed");

// Next-cycle implication.
`define BSRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bsrl assertion failed");

`else

`define BSRL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSRL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/bsrl_pkg.sv
// Package for the backend selector: sizes, codes and inter-module structs.
`default_nettype none

package bsrl_pkg;

	localparam int MAX_BACKENDS = 8;
	localparam int COUNT_WIDTH  = 16;
	localparam int IDX_W        = 3;  // backend_index / chosen_backend field width
	localparam int N_W          = 4;  // backend_count register width
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_BACKEND_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY_MODE = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		FUNC_SELECT = 2'd0,
		FUNC_HEALTH = 2'd1,
		FUNC_INC    = 2'd2,
		FUNC_DEC    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Scan word handed from cell to cell.
	typedef struct packed {
		logic                   tok;
		logic                   have_hi;   // first healthy at or after the pointer
		logic [IDX_W-1:0]       idx_hi;
		logic                   have_lo;   // first healthy before the pointer
		logic [IDX_W-1:0]       idx_lo;
		logic                   have_min;  // least-connections candidate
		logic [IDX_W-1:0]       idx_min;
		logic [COUNT_WIDTH-1:0] cnt_min;
	} link_t;

	// Broadcast scan context.
	typedef struct packed {
		logic [N_W-1:0]   n;
		logic [IDX_W-1:0] start;
	} scan_ctx_t;

	// Broadcast state update.
	typedef struct packed {
		logic             en;
		func_t            func;
		logic [IDX_W-1:0] idx;
		logic             healthy;
	} upd_t;

endpackage

`default_nettype wire

### rtl/backend_selector_rr_least_conn.sv
// Backend selector top level: round robin or least connections over a chain of cells.
//
// Input channel (in_valid / in_stall) takes one command word: select, set health,
// increment or decrement the connection count of backend_index. Only a select
// produces an output word (found, chosen_backend) on out_valid / out_stall.
// Updates take effect at the accepting edge; the next word may follow in the next cycle.
// A select launches a scan word through the row of MAX_BACKENDS cells, one cell a
// cycle, and its result is loaded into the output register as the word leaves the
// last cell; in_stall is held high until then, so the next select waits for that scan.
// Updates are taken one a cycle while no select is in flight.
// If the output word is still stalled when a scan finishes, the result is parked and
// in_stall stays high until the output register frees. A word may be accepted while
// a previous output word waits.
// The user must write configuration (cfg_wr_en, cfg_index, cfg_data) only while idle;
// the block does not enforce it. Writing backend_count clears the rotation pointer.
// Reset: all backends healthy, counts zero, pointer zero, backend_count 0, round robin.
`default_nettype none

`include "backend_selector_rr_least_conn_defines.svh"

module backend_selector_rr_least_conn
	import bsrl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            func,
	input  wire logic [IDX_W-1:0]      backend_index,
	input  wire logic                  healthy,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic [IDX_W-1:0]           chosen_backend,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	state_t             state_q, state_nxt;
	logic [N_W-1:0]     count_q;
	logic               mode_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [N_W-1:0]     n_eff;
	logic               out_valid_q;
	logic               found_q;
	logic [IDX_W-1:0]   chosen_q;
	logic               res_found_q;
	logic [IDX_W-1:0]   res_idx_q;

	logic               accept;
	func_t              cmd;
	scan_ctx_t          ctx;
	upd_t               upd;
	link_t              link [MAX_BACKENDS+1];
	logic [MAX_BACKENDS-1:0] tok_v;
	link_t              last;
	logic               done;
	logic               sel_found;
	logic [IDX_W-1:0]   sel_idx;
	logic               out_free;
	logic               load_scan;
	logic               load_hold;
	logic               park;
	logic [N_W-1:0]     ptr_inc;

	assign n_eff  = (count_q > N_W'(MAX_BACKENDS)) ? N_W'(MAX_BACKENDS) : count_q;
	assign cmd    = func_t'(func);
	assign accept = in_valid && !in_stall;

	assign ctx.n     = n_eff;
	assign ctx.start = ptr_q;

	assign upd.en      = accept && (cmd != FUNC_SELECT) && ({1'b0, backend_index} < n_eff);
	assign upd.func    = cmd;
	assign upd.idx     = backend_index;
	assign upd.healthy = healthy;

	always_comb begin
		link[0]     = '0;
		link[0].tok = accept && (cmd == FUNC_SELECT);
	end

	for (genvar g = 0; g < MAX_BACKENDS; g++) begin : g_cell
		bsrl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.ctx      (ctx),
			.upd      (upd),
			.link_in  (link[g]),
			.link_out (link[g+1])
		);
		assign tok_v[g] = link[g+1].tok;
	end

	assign last = link[MAX_BACKENDS];
	assign done = (state_q == ST_SCAN) && last.tok;

	always_comb begin
		if (mode_q) begin
			sel_found = last.have_min;
			sel_idx   = last.idx_min;
		end else begin
			sel_found = last.have_hi || last.have_lo;
			sel_idx   = last.have_hi ? last.idx_hi : last.idx_lo;
		end
		if (!sel_found) sel_idx = '0;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign ptr_inc  = {1'b0, ptr_q} + N_W'(1);

	always_comb begin
		state_nxt = state_q;
		load_scan = 1'b0;
		load_hold = 1'b0;
		park      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == FUNC_SELECT)) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (done) begin
					if (out_free) begin
						load_scan = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						park      = 1'b1;
						state_nxt = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_hold = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
			ptr_q   <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == REG_BACKEND_COUNT)) begin
				count_q <= cfg_data[N_W-1:0];
				ptr_q   <= '0;
			end else if (done && !mode_q && sel_found) begin
				ptr_q <= (ptr_inc == n_eff) ? '0 : ptr_inc[IDX_W-1:0];
			end
			if (cfg_wr_en && (cfg_index == REG_STRATEGY_MODE)) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_scan || load_hold) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_scan) begin
			found_q  <= sel_found;
			chosen_q <= sel_idx;
		end else if (load_hold) begin
			found_q  <= res_found_q;
			chosen_q <= res_idx_q;
		end
		if (park) begin
			res_found_q <= sel_found;
			res_idx_q   <= sel_idx;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign chosen_backend = chosen_q;

	// a select starts a scan
	`BSRL_ASSERT_NXT(a_sel_scans, clk, arst_n, accept && (cmd == FUNC_SELECT), state_q == ST_SCAN)
	// only one scan word in the chain
	`BSRL_ASSERT_IMP(a_one_tok, clk, arst_n, 1'b1, $onehot0(tok_v))
	// scan word leaves the chain only while scanning
	`BSRL_ASSERT_IMP(a_tok_scan, clk, arst_n, last.tok, state_q == ST_SCAN)
	// pointer stays reduced
	`BSRL_ASSERT_IMP(a_ptr_range, clk, arst_n, n_eff != '0, ptr_inc <= n_eff)
	// no backend reported when none found
	`BSRL_ASSERT_IMP(a_zero_idx, clk, arst_n, out_valid_q && !found_q, chosen_q == '0)

endmodule

`default_nettype wire

### rtl/bsrl_cell.sv
// One backend cell: health bit, connection count and one stage of the scan chain.
`default_nettype none

module bsrl_cell
	import bsrl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] cell_idx,
	input  wire scan_ctx_t        ctx,
	input  wire upd_t             upd,
	input  wire link_t            link_in,
	output link_t                 link_out
);

	logic                   health_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   tok_q;
	link_t                  link_q;
	link_t                  link_nxt;
	logic                   live;
	logic                   hit;

	assign hit  = upd.en && (upd.idx == cell_idx);
	assign live = health_q && ({1'b0, cell_idx} < ctx.n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= 1'b1;
			cnt_q    <= '0;
		end else if (hit) begin
			case (upd.func)
				FUNC_HEALTH: health_q <= upd.healthy;
				FUNC_INC:    if (cnt_q != {COUNT_WIDTH{1'b1}}) cnt_q <= cnt_q + COUNT_WIDTH'(1);
				FUNC_DEC:    if (cnt_q != '0) cnt_q <= cnt_q - COUNT_WIDTH'(1);
				default:     ;
			endcase
		end
	end

	always_comb begin
		link_nxt = link_in;
		if (live && !link_in.have_hi && (cell_idx >= ctx.start)) begin
			link_nxt.have_hi = 1'b1;
			link_nxt.idx_hi  = cell_idx;
		end
		if (live && !link_in.have_lo && (cell_idx < ctx.start)) begin
			link_nxt.have_lo = 1'b1;
			link_nxt.idx_lo  = cell_idx;
		end
		// strict less: ties stay with the lower index
		if (live && (!link_in.have_min || (cnt_q < link_in.cnt_min))) begin
			link_nxt.have_min = 1'b1;
			link_nxt.idx_min  = cell_idx;
			link_nxt.cnt_min  = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= link_in.tok;
		end
	end

	always_ff @(posedge clk) begin
		link_q <= link_nxt;
	end

	always_comb begin
		link_out     = link_q;
		link_out.tok = tok_q;
	end

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the round-robin / least-connections backend selector.
`timescale 1ns / 1ps

module tb_top;
	import bsrl_pkg::*;

	localparam int SETTLE_CYCLES = MAX_BACKENDS + 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] backend;
	} pick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            func;
	logic [IDX_W-1:0]      backend_index;
	logic                  healthy;
	logic                  out_valid;
	logic                  out_stall;
	logic                  found;
	logic [IDX_W-1:0]      chosen_backend;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic                   pool_health [MAX_BACKENDS];
	logic [COUNT_WIDTH-1:0] pool_conns [MAX_BACKENDS];
	int                     rr_ptr;
	logic [N_W-1:0]         pool_size;
	logic                   least_conn_mode;

	pick_t pending_picks[$];
	pick_t head_pick;
	int    idle_pct;
	int    stall_pct;
	int    fail_count;
	int    words_sent;
	int    picks_checked;

	backend_selector_rr_least_conn i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.backend_index  (backend_index),
		.healthy        (healthy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.chosen_backend (chosen_backend),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	function automatic int active_backends();
		return (pool_size > MAX_BACKENDS) ? MAX_BACKENDS : int'(pool_size);
	endfunction

	// Updates the predictor for one accepted word; a select queues its pick.
	function automatic void predict_command(input logic [1:0] f, input logic [IDX_W-1:0] idx,
			input logic h);
		int    n;
		int    start;
		int    k;
		int    i;
		pick_t p;
		n = active_backends();
		p = '0;
		if (f == FUNC_SELECT) begin
			if (least_conn_mode) begin
				for (i = 0; i < n; i++) begin
					if (pool_health[i] && (!p.found || pool_conns[i] < pool_conns[p.backend])) begin
						p.found = 1'b1;
						p.backend = IDX_W'(i);
					end
				end
			end else if (n > 0) begin
				start = rr_ptr % n;
				for (i = 0; i < n && !p.found; i++) begin
					k = (start + i) % n;
					if (pool_health[k]) begin
						p.found = 1'b1;
						p.backend = IDX_W'(k);
						rr_ptr = (start + 1) % n;
					end
				end
			end
			pending_picks = {pending_picks, p};
		end else if (int'(idx) < n) begin
			case (f)
				FUNC_HEALTH: pool_health[idx] = h;
				FUNC_INC: begin
					if (pool_conns[idx] != '1)
						pool_conns[idx] = pool_conns[idx] + 1'b1;
				end
				default: begin
					if (pool_conns[idx] != '0)
						pool_conns[idx] = pool_conns[idx] - 1'b1;
				end
			endcase
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_picks.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual found %0b backend %0d",
					$time, found, chosen_backend);
				fail_count++;
			end else begin
				head_pick = pending_picks.pop_front();
				picks_checked++;
				if (found !== head_pick.found) begin
					$display("%0t: found mismatch: expected %0b, actual %0b",
						$time, head_pick.found, found);
					fail_count++;
				end
				if (chosen_backend !== head_pick.backend) begin
					$display("%0t: chosen_backend mismatch: expected %0d, actual %0d",
						$time, head_pick.backend, chosen_backend);
					fail_count++;
				end
			end
		end
	end

	task automatic send_word(input func_t f, input logic [IDX_W-1:0] idx, input logic h);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		backend_index = idx;
		healthy = h;
		do
			@(posedge clk);
		while (in_stall);
		predict_command(f, idx, h);
		words_sent++;
	endtask

	// Holds the sender off until every pick is back and any update has finished.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		settle();
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		case (idx)
			REG_BACKEND_COUNT: begin
				pool_size = d;
				rr_ptr = 0;
			end
			REG_STRATEGY_MODE: least_conn_mode = d[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic random_word();
		int               n;
		int               sel;
		func_t            f;
		logic [IDX_W-1:0] idx;
		n = active_backends();
		sel = $urandom_range(99);
		if (sel < 40)
			f = FUNC_SELECT;
		else if (sel < 60)
			f = FUNC_HEALTH;
		else if (sel < 85)
			f = FUNC_INC;
		else
			f = FUNC_DEC;
		// mostly in range, some words with a random index that may fall past the pool
		if (n > 0 && $urandom_range(99) < 80)
			idx = IDX_W'($urandom_range(n - 1));
		else
			idx = IDX_W'($urandom);
		send_word(f, idx, $urandom_range(99) < 65);
	endtask

	task automatic test_no_backends();
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_INC, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd0, 1'b0);
		send_word(FUNC_SELECT, 3'd7, 1'b1);
	endtask

	task automatic test_round_robin();
		write_reg(REG_BACKEND_COUNT, 4'd4);
		repeat (5) send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd1, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		// out of the pool: must be ignored
		send_word(FUNC_HEALTH, 3'd7, 1'b0);
		send_word(FUNC_HEALTH, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd2, 1'b0);
		send_word(FUNC_HEALTH, 3'd3, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd3, 1'b1);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd0, 1'b1);
		send_word(FUNC_HEALTH, 3'd2, 1'b1);
		// rewriting the size puts the pointer back to zero
		write_reg(REG_BACKEND_COUNT, 4'd4);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
	endtask

	task automatic test_least_conn();
		write_reg(REG_STRATEGY_MODE, 4'd1);
		send_word(FUNC_INC, 3'd3, 1'b0);
		send_word(FUNC_INC, 3'd3, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_DEC, 3'd0, 1'b0);
		send_word(FUNC_INC, 3'd0, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd1, 1'b1);
		send_word(FUNC_INC, 3'd1, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
	endtask

	task automatic test_register_edges();
		// a size above the maximum acts as the maximum
		write_reg(REG_BACKEND_COUNT, 4'd15);
		send_word(FUNC_INC, 3'd7, 1'b0);
		send_word(FUNC_HEALTH, 3'd5, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		write_reg(REG_BACKEND_COUNT, 4'd8);
		write_reg(REG_SPARE_2, 4'hF);
		write_reg(REG_SPARE_3, 4'hF);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		write_reg(REG_STRATEGY_MODE, 4'd0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		write_reg(REG_BACKEND_COUNT, 4'd0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
	endtask

	task automatic test_random();
		int idle_tab[4]  = '{0, 79, 0, 33};
		int stall_tab[4] = '{0, 0, 79, 33};
		int size_tab[16] = '{8, 3, 1, 0, 15, 5, 2, 8, 4, 9, 7, 6, 8, 2, 12, 1};
		int ph;
		int s;
		int j;
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (s = 0; s < 4; s++) begin
				write_reg(REG_BACKEND_COUNT, N_W'(size_tab[ph * 4 + s]));
				write_reg(REG_STRATEGY_MODE, CFG_DATA_W'((ph + s) % 2));
				for (j = 0; j < 122; j++) begin
					random_word();
					if (j == 61)
						settle();
				end
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_count_saturation();
		write_reg(REG_BACKEND_COUNT, 4'd2);
		write_reg(REG_STRATEGY_MODE, 4'd1);
		send_word(FUNC_HEALTH, 3'd0, 1'b1);
		send_word(FUNC_HEALTH, 3'd1, 1'b1);
		// decrements at zero must hold backend 1 at zero
		repeat (20) send_word(FUNC_DEC, 3'd1, 1'b0);
		repeat (3) send_word(FUNC_INC, 3'd0, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_DEC, 3'd0, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
		send_word(FUNC_HEALTH, 3'd1, 1'b0);
		send_word(FUNC_SELECT, 3'd0, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_SELECT;
		backend_index = '0;
		healthy = 1'b0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_BACKEND_COUNT;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		words_sent = 0;
		picks_checked = 0;
		foreach (pool_health[i]) begin
			pool_health[i] = 1'b1;
			pool_conns[i] = '0;
		end
		rr_ptr = 0;
		pool_size = '0;
		least_conn_mode = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_backends();
		test_round_robin();
		test_least_conn();
		test_register_edges();
		test_random();
		test_count_saturation();
		settle();

		$display("Sent %0d command words, checked %0d selections, pool sizes 0 to 15,",
			words_sent, picks_checked);
		$display("both strategies, four idle/stall mixes and counts held at zero.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout", $time);
		$display("Some tests failed");
		$finish;
	end

endmodule
